[rtl/slfd_pkg.sv]
// Shared types and constants for the sync/length frame deframer.
// No dependencies; imported by the core and its checker.

package slfd_pkg;

   localparam int POS_W = 17;

   // Saturation value of the byte position counter
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Header offsets within a frame
   localparam logic [POS_W-1:0] POS_SYNC0  = 17'd0;
   localparam logic [POS_W-1:0] POS_SYNC1  = 17'd1;
   localparam logic [POS_W-1:0] POS_SIZE_H = 17'd2;
   localparam logic [POS_W-1:0] POS_SIZE_L = 17'd3;
   localparam logic [POS_W-1:0] POS_TYPE   = 17'd4;
   localparam logic [POS_W-1:0] POS_ID_H   = 17'd5;
   localparam logic [POS_W-1:0] POS_ID_L   = 17'd6;
   localparam logic [POS_W-1:0] POS_BODY   = 17'd7;

   localparam logic [7:0] SYNC_BYTE0   = 8'hAA;
   localparam logic [7:0] SYNC_BYTE1   = 8'h55;
   localparam logic [7:0] FOOTER_BYTE0 = 8'h55;
   localparam logic [7:0] FOOTER_BYTE1 = 8'hAA;

   // Size field counts type and id bytes as well as the body
   localparam logic [15:0] MIN_SIZE   = 16'd3;
   localparam logic [POS_W-1:0] MIN_LEN   = 17'd7;
   localparam logic [POS_W-1:0] FOOT0_OFS = 17'd4;
   localparam logic [POS_W-1:0] FOOT1_OFS = 17'd5;
   localparam logic [POS_W-1:0] HDR_OVH   = 17'd3;

   typedef enum logic [1:0] {
      FOOT_NONE  = 2'd0,
      FOOT_FIRST = 2'd1,
      FOOT_BOTH  = 2'd2
   } footer_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT      = 3'd1,
      ST_BAD_SYNC   = 3'd2,
      ST_TOO_LARGE  = 3'd3,
      ST_EMPTY      = 3'd4,
      ST_BAD_FOOTER = 3'd5
   } status_type;

endpackage

[rtl/sync_length_frame_deframer_core.sv]
// Sync/length framed deframer core: header capture, body pass-through, end checks.
// Depends on slfd_pkg.
//
// Usage:
//  - req_ channel carries one buffer byte per beat, req_last_byte on the final one.
//  - rsp_ channel returns exactly one beat per request beat, in order. Body bytes
//    come out flagged by rsp_body_valid as soon as they arrive; the beat for the
//    final byte has rsp_frame_done set with status, type, id and declared size.
//  - The result of a byte is registered and offered from the cycle after the byte
//    is accepted. Throughput is one byte per cycle while the receiver is ready, set by
//    the single result register; the position compare and header update sit in one stage.
//  - When the receiver stalls, the result register holds its beat and
//    req_ready follows rsp_ready, so one byte can still be taken in the cycle
//    that the pending beat leaves.
//  - Reset (synchronous, active high) empties the result register and returns
//    the parser to the start of a buffer. After each final byte the parser
//    clears itself for the next buffer.
//  - Status codes: ok, short, bad sync, too large, empty body, bad footer.

module sync_length_frame_deframer_core
   import slfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_body_valid,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_frame_done,
   output logic [2:0]  rsp_frame_status,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_frame_id,
   output logic [15:0] rsp_declared_size
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             sync_ff, sync_in;
   logic [15:0]      size_ff, size_in;
   logic [7:0]       type_ff, type_in;
   logic [15:0]      id_ff, id_in;
   footer_type       foot_ff, foot_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             body_valid_ff, body_valid_in;
   logic [7:0]       body_byte_ff, body_byte_in;
   logic             done_ff, done_in;
   status_type       status_ff, status_in;
   logic [7:0]       ftype_ff, ftype_in;
   logic [15:0]      fid_ff, fid_in;
   logic [15:0]      fsize_ff, fsize_in;

   logic             accept;
   logic             in_body_zone;
   logic [POS_W-1:0] size_ext;
   logic [POS_W-1:0] len;
   status_type       status_calc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign size_ext = {1'b0, size_ff};
   assign len      = (pos_ff != POS_MAX) ? pos_ff + 17'd1 : POS_MAX;

   // Header capture and footer tracking
   always_comb begin
      sync_in = sync_ff;
      size_in = size_ff;
      type_in = type_ff;
      id_in   = id_ff;
      foot_in = foot_ff;
      case (pos_ff)
         POS_SYNC0:  if (req_data_byte != SYNC_BYTE0) sync_in = 1'b0;
         POS_SYNC1:  if (req_data_byte != SYNC_BYTE1) sync_in = 1'b0;
         POS_SIZE_H: size_in = {req_data_byte, size_ff[7:0]};
         POS_SIZE_L: size_in = {size_ff[15:8], req_data_byte};
         POS_TYPE:   type_in = req_data_byte;
         POS_ID_H:   id_in   = {req_data_byte, id_ff[7:0]};
         POS_ID_L:   id_in   = {id_ff[15:8], req_data_byte};
         default: ;
      endcase

      in_body_zone = (pos_ff >= POS_BODY) && (size_ff >= MIN_SIZE);
      if (in_body_zone) begin
         if (pos_ff == size_ext + FOOT0_OFS) begin
            foot_in = (req_data_byte == FOOTER_BYTE0) ? FOOT_FIRST : FOOT_NONE;
         end else if (pos_ff == size_ext + FOOT1_OFS) begin
            foot_in = (foot_ff == FOOT_FIRST && req_data_byte == FOOTER_BYTE1) ?
                      FOOT_BOTH : FOOT_NONE;
         end
      end
   end

   // End-of-buffer checks, in priority order
   always_comb begin
      if (len < MIN_LEN) begin
         status_calc = ST_SHORT;
      end else if (!sync_in) begin
         status_calc = ST_BAD_SYNC;
      end else if (size_in < MIN_SIZE || ({1'b0, size_in} + HDR_OVH) > len) begin
         status_calc = ST_TOO_LARGE;
      end else if (size_in == MIN_SIZE || len == MIN_LEN) begin
         status_calc = ST_EMPTY;
      end else if (foot_in != FOOT_BOTH) begin
         status_calc = ST_BAD_FOOTER;
      end else begin
         status_calc = ST_OK;
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      body_valid_in = body_valid_ff;
      body_byte_in  = body_byte_ff;
      done_in       = done_ff;
      status_in     = status_ff;
      ftype_in      = ftype_ff;
      fid_in        = fid_ff;
      fsize_in      = fsize_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         body_valid_in = in_body_zone && sync_ff && (pos_ff < size_ext + FOOT0_OFS);
         body_byte_in  = body_valid_in ? req_data_byte : 8'd0;
         done_in       = req_last_byte;
         status_in     = req_last_byte ? status_calc : ST_OK;
         ftype_in      = req_last_byte ? type_in : 8'd0;
         fid_in        = req_last_byte ? id_in : 16'd0;
         fsize_in      = req_last_byte ? size_in : 16'd0;
         if (!req_last_byte && pos_ff != POS_MAX) begin
            pos_in = pos_ff + 17'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sync_ff      <= 1'b1;
         size_ff      <= '0;
         type_ff      <= '0;
         id_ff        <= '0;
         foot_ff      <= FOOT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept && req_last_byte) begin
            pos_ff  <= '0;
            sync_ff <= 1'b1;
            size_ff <= '0;
            type_ff <= '0;
            id_ff   <= '0;
            foot_ff <= FOOT_NONE;
         end else if (accept) begin
            pos_ff  <= pos_in;
            sync_ff <= sync_in;
            size_ff <= size_in;
            type_ff <= type_in;
            id_ff   <= id_in;
            foot_ff <= foot_in;
         end
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      body_valid_ff <= body_valid_in;
      body_byte_ff  <= body_byte_in;
      done_ff       <= done_in;
      status_ff     <= status_in;
      ftype_ff      <= ftype_in;
      fid_ff        <= fid_in;
      fsize_ff      <= fsize_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_body_valid    = body_valid_ff;
   assign rsp_body_byte     = body_byte_ff;
   assign rsp_frame_done    = done_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_frame_type    = ftype_ff;
   assign rsp_frame_id      = fid_ff;
   assign rsp_declared_size = fsize_ff;

endmodule

[rtl/slfd_checker.sv]
// Port-level checker for the deframer core, bound into the deframer core.
// Depends on slfd_pkg and sync_length_frame_deframer_core.

module slfd_checker
   import slfd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_body_valid,
   input logic [7:0]  rsp_body_byte,
   input logic        rsp_frame_done,
   input logic [2:0]  rsp_frame_status,
   input logic [7:0]  rsp_frame_type,
   input logic [15:0] rsp_frame_id,
   input logic [15:0] rsp_declared_size
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_body_byte) &&
      $stable(rsp_frame_done) && $stable(rsp_frame_status))
      else $error("result beat changed while stalled");

   // Frame summary fields are zero except on the final-byte beat
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_frame_status == ST_OK &&
      rsp_frame_type == 8'd0 && rsp_frame_id == 16'd0 && rsp_declared_size == 16'd0)
      else $error("frame summary set on a non-final beat");

   a_body_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_body_valid |-> rsp_body_byte == 8'd0)
      else $error("body byte set without body flag");

   // On the final-byte beat, a body byte needs a good sync and at least a full header
   a_body_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_valid && rsp_frame_done |->
      rsp_frame_status != ST_SHORT && rsp_frame_status != ST_BAD_SYNC)
      else $error("body byte on a short or unsynced buffer");

   a_no_beat_unasked: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("result beat without a request beat");

endmodule

bind sync_length_frame_deframer_core slfd_checker u_slfd_checker (.*);
